// ----- rtl/mtwm_pkg.sv -----
// ----------------------------------------------------------------------------
// Morph target mix package
// Shared constants, command types and the result clamp for the morph target
// weighted mix block.
// ----------------------------------------------------------------------------
package mtwm_pkg;

  localparam int NUM_SHAPES_DEF  = 52;
  localparam int MAX_TARGETS_DEF = 16;

  // Address width that covers the target store over the whole parameter range.
  localparam int STORE_AW    = 11;
  localparam int DATA_W      = 17;
  localparam int ENTRY_W     = 16;
  localparam int SHAPE_IDX_W = 6;
  localparam int STATUS_W    = 2;
  localparam int WPOS_W      = 5;
  localparam int ACC_W       = 40;
  localparam int PROD_W      = 34;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [WPOS_W-1:0]  WPOS_MAX = 5'd31;
  localparam logic [ENTRY_W-1:0] Q_ONE    = 16'd32768;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_APPLY = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_MIX     = 2'd0,
    ST_STORED  = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CMD_ENTRY = 1'b0,
    CMD_MAC   = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic                  wr;
    logic                  rep;
    status_e               st;
    logic [STORE_AW-1:0]   addr;
    logic [DATA_W-1:0]     data;
    logic                  clr;
    logic                  fin;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ENTRY,
    BK_STATUS,
    BK_MAC,
    BK_DRAIN,
    BK_EMIT_RD,
    BK_EMIT_WAIT
  } back_state_e;

  function automatic logic [ENTRY_W-1:0] clamp_acc(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-16:0] q;
    logic [ENTRY_W-1:0] r;
    q = a[ACC_W-1:15];
    if (a[ACC_W-1]) begin
      r = '0;
    end else if (q > (ACC_W-15)'(Q_ONE)) begin
      r = Q_ONE;
    end else begin
      r = q[ENTRY_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/morph_target_weighted_mix.sv -----
// ----------------------------------------------------------------------------
// Morph target weighted mix
// Stores morph targets and mixes them with signed weights into clamped
// per-shape values.
// ----------------------------------------------------------------------------
// The input channel carries one operation per transaction: clear the table,
// add one target entry, or apply one weight. The output channel carries one
// result per transaction: a status after the last entry of an add run, or
// NUM_SHAPES mixed shape values after the weight marked final.
// The front end accepts a transaction whenever its command queue has room,
// so bursts of items are taken at full speed until the queue fills.
// The back end serializes the work: an entry write is done in the entry
// state, a weight runs one multiply-accumulate per shape through the single
// accumulator memory followed by pipeline drain, and the final sweep emits
// the shape values one at a time through a read and a wait state each. The
// status result is loaded in the status state after the last entry write.
// The target store is not cleared at reset; reset empties the table counters
// and queue at once, and the block accepts items as soon as reset is released.
// When the receiver stalls, the result register holds its transaction and
// the back end waits; the queue keeps taking input until it is full.
// ----------------------------------------------------------------------------
module morph_target_weighted_mix #(
  parameter int NUM_SHAPES  = mtwm_pkg::NUM_SHAPES_DEF,
  parameter int MAX_TARGETS = mtwm_pkg::MAX_TARGETS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic [mtwm_pkg::ENTRY_W-1:0]        target_entry_i,
  input  logic signed [mtwm_pkg::DATA_W-1:0]  mix_weight_i,
  input  logic                                final_weight_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mtwm_pkg::SHAPE_IDX_W-1:0]    shape_index_o,
  output logic [mtwm_pkg::ENTRY_W-1:0]        shape_value_o,
  output logic [mtwm_pkg::STATUS_W-1:0]       status_o,
  output logic                                last_o
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  mtwm_pkg::cmd_t cmd;
  mtwm_pkg::cmd_t head;

  mtwm_front #(
    .NUM_SHAPES  (NUM_SHAPES),
    .MAX_TARGETS (MAX_TARGETS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .target_entry_i (target_entry_i),
    .mix_weight_i   (mix_weight_i),
    .final_weight_i (final_weight_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  mtwm_queue #(
    .DEPTH (mtwm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  mtwm_back #(
    .NUM_SHAPES  (NUM_SHAPES),
    .MAX_TARGETS (MAX_TARGETS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .shape_index_o (shape_index_o),
    .shape_value_o (shape_value_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

// ----- rtl/mtwm_front.sv -----
// ----------------------------------------------------------------------------
// Morph target mix front end
// Accepts input transactions, tracks table and run positions and turns the add
// and apply items that need work into commands for the back end.
// ----------------------------------------------------------------------------
module mtwm_front #(
  parameter int NUM_SHAPES  = mtwm_pkg::NUM_SHAPES_DEF,
  parameter int MAX_TARGETS = mtwm_pkg::MAX_TARGETS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      operation_i,
  input  logic [mtwm_pkg::ENTRY_W-1:0]    target_entry_i,
  input  logic signed [mtwm_pkg::DATA_W-1:0] mix_weight_i,
  input  logic                            final_weight_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output mtwm_pkg::cmd_t                  cmd_o
);

  localparam int SW    = (NUM_SHAPES > 1) ? $clog2(NUM_SHAPES) : 1;
  localparam int CW    = $clog2(MAX_TARGETS + 1);
  localparam int DEPTH = NUM_SHAPES * MAX_TARGETS;
  localparam int BW    = $clog2(DEPTH + 1);
  localparam logic [SW-1:0] LAST_POS  = SW'(NUM_SHAPES - 1);
  localparam logic [BW-1:0] BASE_STEP = BW'(NUM_SHAPES);
  localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_TARGETS);

  logic [CW-1:0]               cnt_q, cnt_d;
  logic [SW-1:0]               lpos_q, lpos_d;
  logic [mtwm_pkg::WPOS_W-1:0] wpos_q, wpos_d;
  logic [BW-1:0]               sbase_q, sbase_d;
  logic [BW-1:0]               wbase_q, wbase_d;
  logic                        accept;
  logic                        room;
  logic                        ld_last;
  logic                        w_valid;
  logic [mtwm_pkg::ENTRY_W-1:0] entry_sat;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign room       = cnt_q < CNT_MAX;
  assign ld_last    = lpos_q == LAST_POS;
  assign w_valid    = wpos_q < mtwm_pkg::WPOS_W'(cnt_q);
  assign entry_sat  = (target_entry_i > mtwm_pkg::Q_ONE) ? mtwm_pkg::Q_ONE : target_entry_i;

  always_comb begin
    cnt_d   = cnt_q;
    lpos_d  = lpos_q;
    wpos_d  = wpos_q;
    sbase_d = sbase_q;
    wbase_d = wbase_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    if (accept) begin
      case (operation_i)
        mtwm_pkg::OP_CLEAR: begin
          cnt_d   = '0;
          lpos_d  = '0;
          wpos_d  = '0;
          sbase_d = '0;
          wbase_d = '0;
        end
        mtwm_pkg::OP_ADD: begin
          cmd_o.kind = mtwm_pkg::CMD_ENTRY;
          cmd_o.wr   = room;
          cmd_o.rep  = ld_last;
          cmd_o.st   = room ? mtwm_pkg::ST_STORED : mtwm_pkg::ST_DROPPED;
          cmd_o.addr = mtwm_pkg::STORE_AW'(sbase_q) + mtwm_pkg::STORE_AW'(lpos_q);
          cmd_o.data = {1'b0, entry_sat};
          push_o     = room || ld_last;
          if (ld_last) begin
            lpos_d = '0;
            if (room) begin
              cnt_d   = cnt_q + CW'(1);
              sbase_d = sbase_q + BASE_STEP;
            end
          end else begin
            lpos_d = lpos_q + SW'(1);
          end
        end
        mtwm_pkg::OP_APPLY: begin
          cmd_o.kind = mtwm_pkg::CMD_MAC;
          cmd_o.wr   = w_valid;
          cmd_o.addr = mtwm_pkg::STORE_AW'(wbase_q);
          cmd_o.data = w_valid ? mix_weight_i : '0;
          cmd_o.clr  = wpos_q == '0;
          cmd_o.fin  = final_weight_i;
          push_o     = w_valid || (wpos_q == '0) || final_weight_i;
          if (w_valid) begin
            wbase_d = wbase_q + BASE_STEP;
          end
          if (final_weight_i) begin
            wpos_d  = '0;
            wbase_d = '0;
          end else if (wpos_q != mtwm_pkg::WPOS_MAX) begin
            wpos_d = wpos_q + mtwm_pkg::WPOS_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      lpos_q  <= '0;
      wpos_q  <= '0;
      sbase_q <= '0;
      wbase_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      lpos_q  <= lpos_d;
      wpos_q  <= wpos_d;
      sbase_q <= sbase_d;
      wbase_q <= wbase_d;
    end
  end

endmodule

// ----- rtl/mtwm_queue.sv -----
// ----------------------------------------------------------------------------
// Morph target mix command queue
// Short first-in first-out buffer of commands between front and back end.
// ----------------------------------------------------------------------------
module mtwm_queue #(
  parameter int DEPTH = mtwm_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mtwm_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output mtwm_pkg::cmd_t head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  mtwm_pkg::cmd_t entries_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o  = cnt_q == NW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule

// ----- rtl/mtwm_back.sv -----
// ----------------------------------------------------------------------------
// Morph target mix back end
// Executes queued commands: target store writes, status results, per-shape
// multiply-accumulate sweeps and the clamped emission of all shape sums.
// ----------------------------------------------------------------------------
module mtwm_back #(
  parameter int NUM_SHAPES  = mtwm_pkg::NUM_SHAPES_DEF,
  parameter int MAX_TARGETS = mtwm_pkg::MAX_TARGETS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  mtwm_pkg::cmd_t                   q_head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mtwm_pkg::SHAPE_IDX_W-1:0] shape_index_o,
  output logic [mtwm_pkg::ENTRY_W-1:0]     shape_value_o,
  output logic [mtwm_pkg::STATUS_W-1:0]    status_o,
  output logic                             last_o
);

  localparam int SW    = (NUM_SHAPES > 1) ? $clog2(NUM_SHAPES) : 1;
  localparam int DEPTH = NUM_SHAPES * MAX_TARGETS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SW-1:0] LAST_POS = SW'(NUM_SHAPES - 1);

  mtwm_pkg::back_state_e state_q, state_d;
  mtwm_pkg::cmd_t        cmd_q;

  logic [mtwm_pkg::ENTRY_W-1:0]       tgt_mem [DEPTH];
  logic signed [mtwm_pkg::ACC_W-1:0]  acc_mem [NUM_SHAPES];
  logic [mtwm_pkg::ENTRY_W-1:0]       tgt_rdata_q;
  logic signed [mtwm_pkg::ACC_W-1:0]  acc_rdata_q;

  logic [SW-1:0]                      j_q, j_d;
  logic                               v1_q, v2_q;
  logic [SW-1:0]                      j1_q, j2_q;
  logic signed [mtwm_pkg::PROD_W-1:0] prod_q;
  logic signed [mtwm_pkg::ACC_W-1:0]  hold_q;
  logic signed [mtwm_pkg::ACC_W-1:0]  acc_sum;

  logic                               tgt_we, tgt_re, acc_re;
  logic [AW-1:0]                      tgt_raddr;
  logic                               out_free, out_load;
  logic [SW-1:0]                      out_idx_d, out_idx_q;
  logic [mtwm_pkg::ENTRY_W-1:0]       out_val_d, out_val_q;
  mtwm_pkg::status_e                  out_st_d, out_st_q;
  logic                               out_last_d, out_last_q;
  logic                               out_valid_q;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign tgt_raddr = cmd_q.addr[AW-1:0] + AW'(j_q);
  assign acc_sum   = hold_q + mtwm_pkg::ACC_W'(prod_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mtwm_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_head_i.kind == mtwm_pkg::CMD_MAC) ? mtwm_pkg::BK_MAC
                                                         : mtwm_pkg::BK_ENTRY;
        end
      end
      mtwm_pkg::BK_ENTRY: begin
        state_d = cmd_q.rep ? mtwm_pkg::BK_STATUS : mtwm_pkg::BK_IDLE;
      end
      mtwm_pkg::BK_STATUS: begin
        if (out_free) begin
          state_d = mtwm_pkg::BK_IDLE;
        end
      end
      mtwm_pkg::BK_MAC: begin
        if (j_q == LAST_POS) begin
          state_d = mtwm_pkg::BK_DRAIN;
        end
      end
      mtwm_pkg::BK_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = cmd_q.fin ? mtwm_pkg::BK_EMIT_RD : mtwm_pkg::BK_IDLE;
        end
      end
      mtwm_pkg::BK_EMIT_RD: begin
        state_d = mtwm_pkg::BK_EMIT_WAIT;
      end
      mtwm_pkg::BK_EMIT_WAIT: begin
        if (out_free) begin
          state_d = (j_q == LAST_POS) ? mtwm_pkg::BK_IDLE : mtwm_pkg::BK_EMIT_RD;
        end
      end
      default: begin
        state_d = mtwm_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    tgt_we     = 1'b0;
    tgt_re     = 1'b0;
    acc_re     = 1'b0;
    out_load   = 1'b0;
    out_idx_d  = j_q;
    out_val_d  = '0;
    out_st_d   = mtwm_pkg::ST_MIX;
    out_last_d = 1'b0;
    j_d        = j_q;
    case (state_q)
      mtwm_pkg::BK_IDLE: begin
        pop_o = q_valid_i;
      end
      mtwm_pkg::BK_ENTRY: begin
        tgt_we = cmd_q.wr;
      end
      mtwm_pkg::BK_STATUS: begin
        out_load   = out_free;
        out_idx_d  = '0;
        out_st_d   = cmd_q.st;
        out_last_d = 1'b1;
      end
      mtwm_pkg::BK_MAC: begin
        tgt_re = 1'b1;
        acc_re = 1'b1;
        j_d    = (j_q == LAST_POS) ? '0 : j_q + SW'(1);
      end
      mtwm_pkg::BK_EMIT_RD: begin
        acc_re = 1'b1;
      end
      mtwm_pkg::BK_EMIT_WAIT: begin
        out_load   = out_free;
        out_val_d  = mtwm_pkg::clamp_acc(acc_rdata_q);
        out_last_d = j_q == LAST_POS;
        if (out_free) begin
          j_d = (j_q == LAST_POS) ? '0 : j_q + SW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tgt_we) begin
      tgt_mem[cmd_q.addr[AW-1:0]] <= cmd_q.data[mtwm_pkg::ENTRY_W-1:0];
    end
    if (tgt_re) begin
      tgt_rdata_q <= tgt_mem[tgt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_mem[j2_q] <= acc_sum;
    end
    if (acc_re) begin
      acc_rdata_q <= acc_mem[j_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_head_i;
    end
    j1_q <= j_q;
    j2_q <= j1_q;
    if (cmd_q.wr) begin
      prod_q <= $signed(cmd_q.data) * $signed({1'b0, tgt_rdata_q});
    end else begin
      prod_q <= '0;
    end
    hold_q <= cmd_q.clr ? '0 : acc_rdata_q;
    if (out_load) begin
      out_idx_q  <= out_idx_d;
      out_val_q  <= out_val_d;
      out_st_q   <= out_st_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtwm_pkg::BK_IDLE;
      j_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      v1_q    <= state_q == mtwm_pkg::BK_MAC;
      v2_q    <= v1_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign shape_index_o = mtwm_pkg::SHAPE_IDX_W'(out_idx_q);
  assign shape_value_o = out_val_q;
  assign status_o      = out_st_q;
  assign last_o        = out_last_q;

endmodule
